// File: src/sparse_polynomial_adder_unit_defines.svh
// Assertion macros for the sparse polynomial adder checker.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef SPARSE_POLYNOMIAL_ADDER_UNIT_DEFINES_SVH
`define SPARSE_POLYNOMIAL_ADDER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define SPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define SPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/spa_pkg.sv
// Shared types and constants of the sparse polynomial adder.
// No dependencies.
package spa_pkg;

  // Field widths
  localparam int unsigned OpcodeW = 2;
  localparam int unsigned DegW    = 8;
  localparam int unsigned CoefW   = 32;

  // Parameter defaults
  localparam int unsigned MaxTermsDef   = 8;
  localparam int unsigned DegreeBitsDef = 8;

  typedef enum logic [OpcodeW-1:0] {
    OP_LOAD_P  = 2'd0,
    OP_LOAD_Q  = 2'd1,
    OP_COMPUTE = 2'd2
  } opcode_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EMPTY,
    S_P_RD,
    S_Q_RD,
    S_CMP,
    S_P_EMIT,
    S_Q2_RD,
    S_Q2_EMIT,
    S_FLUSH
  } state_e;

  // Port control of one term store
  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

// File: src/spa_if.sv
// Request channels of the sparse polynomial adder: term input and sum output.
// Depends on spa_pkg for field widths.
interface spa_term_if;
  import spa_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OpcodeW-1:0]       opcode;
  logic [DegW-1:0]          term_degree;
  logic signed [CoefW-1:0]  term_coef;

  modport source (output valid, output opcode, output term_degree, output term_coef,
                  input ready);
  modport sink   (input valid, input opcode, input term_degree, input term_coef,
                  output ready);
endinterface

interface spa_sum_if;
  import spa_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [DegW-1:0]          sum_degree;
  logic signed [CoefW-1:0]  sum_coef;
  logic                     present;
  logic                     overflow;
  logic                     last;

  modport source (output valid, output sum_degree, output sum_coef, output present,
                  output overflow, output last, input ready);
  modport sink   (input valid, input sum_degree, input sum_coef, input present,
                  input overflow, input last, output ready);
endinterface

// File: src/sparse_polynomial_adder_unit.sv
// Sparse polynomial adder. A compute request walks every P term against the Q
// terms, alternating Q-store reads and degree compares; the sum channel can stall it.
// Results trail generation by one term (held to mark the last one).
// Reset (async, active low) clears the counts, the dropped flag and the sequencer;
// the term stores keep their contents and are only read below the counts.
module sparse_polynomial_adder_unit #(
  parameter int unsigned MAX_TERMS   = spa_pkg::MaxTermsDef,
  parameter int unsigned DEGREE_BITS = spa_pkg::DegreeBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  spa_term_if.sink    term_i,
  spa_sum_if.source   sum_o
);
  import spa_pkg::*;

  localparam int unsigned IdxW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int unsigned EntW = DEGREE_BITS + CoefW;

  mem_ctl_t         p_ctl, q_ctl;
  logic [IdxW-1:0]  p_waddr, p_raddr, q_waddr, q_raddr;
  logic [EntW-1:0]  p_rdata, q_rdata, wdata;

  // Sequencer
  spa_ctrl #(
    .MAX_TERMS   (MAX_TERMS),
    .DEGREE_BITS (DEGREE_BITS),
    .IDX_W       (IdxW),
    .ENT_W       (EntW)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .term_i    (term_i),
    .sum_o     (sum_o),
    .p_ctl_o   (p_ctl),
    .p_waddr_o (p_waddr),
    .p_raddr_o (p_raddr),
    .p_rdata_i (p_rdata),
    .q_ctl_o   (q_ctl),
    .q_waddr_o (q_waddr),
    .q_raddr_o (q_raddr),
    .q_rdata_i (q_rdata),
    .wdata_o   (wdata)
  );

  // P term store
  spa_term_store #(
    .DEPTH (MAX_TERMS),
    .WIDTH (EntW),
    .AW    (IdxW)
  ) u_p_store (
    .clk_i   (clk_i),
    .ctl_i   (p_ctl),
    .waddr_i (p_waddr),
    .wdata_i (wdata),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  // Q term store
  spa_term_store #(
    .DEPTH (MAX_TERMS),
    .WIDTH (EntW),
    .AW    (IdxW)
  ) u_q_store (
    .clk_i   (clk_i),
    .ctl_i   (q_ctl),
    .waddr_i (q_waddr),
    .wdata_i (wdata),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

endmodule

// File: src/spa_term_store.sv
// One term store: synchronous RAM, one write and one read port, registered read.
// Depends on spa_pkg (mem_ctl_t).
module spa_term_store #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned WIDTH = 40,
  parameter int unsigned AW    = 3
) (
  input  logic                clk_i,
  input  spa_pkg::mem_ctl_t   ctl_i,
  input  logic [AW-1:0]       waddr_i,
  input  logic [WIDTH-1:0]    wdata_i,
  input  logic [AW-1:0]       raddr_i,
  output logic [WIDTH-1:0]    rdata_o
);
  import spa_pkg::*;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port; loads and compute reads never share a cycle
  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (ctl_i.re) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/spa_ctrl.sv
// Sequencer of the sparse polynomial adder: loads, P/Q compare walk,
// one-deep hold stage for the last flag and the output register.
// Depends on spa_pkg and the channel interfaces in spa_if.sv.
module spa_ctrl #(
  parameter int unsigned MAX_TERMS   = spa_pkg::MaxTermsDef,
  parameter int unsigned DEGREE_BITS = spa_pkg::DegreeBitsDef,
  parameter int unsigned IDX_W       = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1,
  parameter int unsigned ENT_W       = DEGREE_BITS + spa_pkg::CoefW
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  spa_term_if.sink           term_i,
  spa_sum_if.source          sum_o,
  output spa_pkg::mem_ctl_t  p_ctl_o,
  output logic [IDX_W-1:0]   p_waddr_o,
  output logic [IDX_W-1:0]   p_raddr_o,
  input  logic [ENT_W-1:0]   p_rdata_i,
  output spa_pkg::mem_ctl_t  q_ctl_o,
  output logic [IDX_W-1:0]   q_waddr_o,
  output logic [IDX_W-1:0]   q_raddr_o,
  input  logic [ENT_W-1:0]   q_rdata_i,
  output logic [ENT_W-1:0]   wdata_o
);
  import spa_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_TERMS + 1);
  localparam int unsigned DW   = DEGREE_BITS;

  state_e               state_q, state_d;
  logic [CntW-1:0]      p_cnt_q, p_cnt_d, q_cnt_q, q_cnt_d;
  logic                 dropped_q, dropped_d;
  logic [IDX_W-1:0]     i_q, i_d, j_q, j_d;
  logic                 p_hit_q, p_hit_d;
  logic [MAX_TERMS-1:0] q_hit_q, q_hit_d;

  // hold stage
  logic                 hold_valid_q, hold_valid_d;
  logic [DW-1:0]        hold_deg_q;
  logic [CoefW-1:0]     hold_coef_q;
  logic                 hold_present_q;

  // output register
  logic                 out_valid_q, out_valid_d;
  logic [DegW-1:0]      out_deg_q;
  logic [CoefW-1:0]     out_coef_q;
  logic                 out_present_q, out_overflow_q, out_last_q;

  // generated result
  logic                 gen_valid, gen_ok, gen_present;
  logic [DW-1:0]        gen_deg;
  logic [CoefW-1:0]     gen_coef;
  logic                 flush, can_push, push;

  logic [DW-1:0]        p_deg, q_deg;
  logic [CoefW-1:0]     p_coef, q_coef;
  logic                 match, i_last, j_last;

  assign p_deg  = p_rdata_i[ENT_W-1 -: DW];
  assign q_deg  = q_rdata_i[ENT_W-1 -: DW];
  assign p_coef = p_rdata_i[CoefW-1:0];
  assign q_coef = q_rdata_i[CoefW-1:0];
  assign match  = (p_deg == q_deg);
  assign i_last = ((CntW'(i_q) + CntW'(1)) == p_cnt_q);
  assign j_last = ((CntW'(j_q) + CntW'(1)) == q_cnt_q);

  assign can_push = !out_valid_q || sum_o.ready;
  assign gen_ok   = !hold_valid_q || can_push;

  // Store write side: degree masked to DEGREE_BITS
  assign wdata_o   = {DW'(term_i.term_degree), term_i.term_coef};
  assign p_waddr_o = p_cnt_q[IDX_W-1:0];
  assign q_waddr_o = q_cnt_q[IDX_W-1:0];
  assign p_raddr_o = i_q;
  assign q_raddr_o = j_q;

  assign term_i.ready = (state_q == S_IDLE);

  // Next state and store control
  always_comb begin
    state_d     = state_q;
    p_cnt_d     = p_cnt_q;
    q_cnt_d     = q_cnt_q;
    dropped_d   = dropped_q;
    i_d         = i_q;
    j_d         = j_q;
    p_hit_d     = p_hit_q;
    q_hit_d     = q_hit_q;
    p_ctl_o     = '0;
    q_ctl_o     = '0;
    gen_valid   = 1'b0;
    gen_present = 1'b1;
    gen_deg     = p_deg;
    gen_coef    = p_coef;
    flush       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (term_i.valid) begin
          unique case (opcode_e'(term_i.opcode))
            OP_LOAD_P: begin
              if (p_cnt_q == CntW'(MAX_TERMS)) begin
                dropped_d = 1'b1;
              end else begin
                p_ctl_o.we = 1'b1;
                p_cnt_d    = p_cnt_q + CntW'(1);
              end
            end
            OP_LOAD_Q: begin
              if (q_cnt_q == CntW'(MAX_TERMS)) begin
                dropped_d = 1'b1;
              end else begin
                q_ctl_o.we = 1'b1;
                q_cnt_d    = q_cnt_q + CntW'(1);
              end
            end
            OP_COMPUTE: begin
              i_d     = '0;
              j_d     = '0;
              p_hit_d = 1'b0;
              q_hit_d = '0;
              if (p_cnt_q == '0 && q_cnt_q == '0) begin
                state_d = S_EMPTY;
              end else if (p_cnt_q != '0) begin
                state_d = S_P_RD;
              end else begin
                state_d = S_Q2_RD;
              end
            end
            default: ;  // unused opcode: no effect
          endcase
        end
      end

      // both polynomials empty: single marker
      S_EMPTY: begin
        gen_valid   = 1'b1;
        gen_present = 1'b0;
        gen_deg     = '0;
        gen_coef    = '0;
        if (gen_ok) begin
          state_d = S_FLUSH;
        end
      end

      S_P_RD: begin
        p_ctl_o.re = 1'b1;
        p_hit_d    = 1'b0;
        j_d        = '0;
        state_d    = (q_cnt_q != '0) ? S_Q_RD : S_P_EMIT;
      end

      S_Q_RD: begin
        q_ctl_o.re = 1'b1;
        state_d    = S_CMP;
      end

      // compare P[i] with Q[j], emit the sum on a match
      S_CMP: begin
        gen_valid = match;
        gen_deg   = q_deg;
        gen_coef  = p_coef + q_coef;
        if (!match || gen_ok) begin
          if (match) begin
            q_hit_d[j_q] = 1'b1;
            p_hit_d      = 1'b1;
          end
          if (!j_last) begin
            j_d     = j_q + IDX_W'(1);
            state_d = S_Q_RD;
          end else if (!(p_hit_q || match)) begin
            state_d = S_P_EMIT;
          end else if (i_last) begin
            j_d     = '0;
            state_d = S_Q2_RD;
          end else begin
            i_d     = i_q + IDX_W'(1);
            state_d = S_P_RD;
          end
        end
      end

      // unmatched P term, unchanged
      S_P_EMIT: begin
        gen_valid = 1'b1;
        if (gen_ok) begin
          if (i_last) begin
            j_d     = '0;
            state_d = S_Q2_RD;
          end else begin
            i_d     = i_q + IDX_W'(1);
            state_d = S_P_RD;
          end
        end
      end

      // Q pass: skip the matched terms
      S_Q2_RD: begin
        if (q_cnt_q == '0) begin
          state_d = S_FLUSH;
        end else if (q_hit_q[j_q]) begin
          if (j_last) begin
            state_d = S_FLUSH;
          end else begin
            j_d = j_q + IDX_W'(1);
          end
        end else begin
          q_ctl_o.re = 1'b1;
          state_d    = S_Q2_EMIT;
        end
      end

      S_Q2_EMIT: begin
        gen_valid = 1'b1;
        gen_deg   = q_deg;
        gen_coef  = q_coef;
        if (gen_ok) begin
          if (j_last) begin
            state_d = S_FLUSH;
          end else begin
            j_d     = j_q + IDX_W'(1);
            state_d = S_Q2_RD;
          end
        end
      end

      // push the held result as last, then clear the counts and the dropped flag
      S_FLUSH: begin
        flush = 1'b1;
        if (can_push) begin
          p_cnt_d   = '0;
          q_cnt_d   = '0;
          dropped_d = 1'b0;
          state_d   = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Hold and output handoff
  assign push = (gen_valid && gen_ok && hold_valid_q) || (flush && can_push);

  always_comb begin
    hold_valid_d = hold_valid_q;
    if (gen_valid && gen_ok) begin
      hold_valid_d = 1'b1;
    end else if (flush && can_push) begin
      hold_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (push) begin
      out_valid_d = 1'b1;
    end else if (sum_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      p_cnt_q      <= '0;
      q_cnt_q      <= '0;
      dropped_q    <= 1'b0;
      i_q          <= '0;
      j_q          <= '0;
      p_hit_q      <= 1'b0;
      q_hit_q      <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      p_cnt_q      <= p_cnt_d;
      q_cnt_q      <= q_cnt_d;
      dropped_q    <= dropped_d;
      i_q          <= i_d;
      j_q          <= j_d;
      p_hit_q      <= p_hit_d;
      q_hit_q      <= q_hit_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (gen_valid && gen_ok) begin
      hold_deg_q     <= gen_deg;
      hold_coef_q    <= gen_coef;
      hold_present_q <= gen_present;
    end
    if (push) begin
      out_deg_q      <= DegW'(hold_deg_q);
      out_coef_q     <= hold_coef_q;
      out_present_q  <= hold_present_q;
      out_overflow_q <= dropped_q;
      out_last_q     <= flush;
    end
  end

  assign sum_o.valid      = out_valid_q;
  assign sum_o.sum_degree = out_deg_q;
  assign sum_o.sum_coef   = signed'(out_coef_q);
  assign sum_o.present    = out_present_q;
  assign sum_o.overflow   = out_overflow_q;
  assign sum_o.last       = out_last_q;

endmodule

// File: src/spa_checker.sv
// Port-level checks of the sparse polynomial adder, bound to the top level.
// Depends on spa_pkg and sparse_polynomial_adder_unit_defines.svh.
`include "sparse_polynomial_adder_unit_defines.svh"

module spa_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [spa_pkg::OpcodeW-1:0]    in_opcode_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [spa_pkg::DegW-1:0]       out_degree_i,
  input  logic [spa_pkg::CoefW-1:0]      out_coef_i,
  input  logic                           out_present_i,
  input  logic                           out_last_i
);
  import spa_pkg::*;

  logic out_stalled, marker, marker_zero, compute_taken;

  // conditions watched below
  assign out_stalled   = out_valid_i && !out_ready_i;
  assign marker        = out_valid_i && !out_present_i;
  assign marker_zero   = (out_degree_i == '0) && (out_coef_i == '0);
  assign compute_taken = in_valid_i && in_ready_i && (in_opcode_i == OP_COMPUTE);

  // a stalled result stays offered
  `SPA_ASSERT_NEXT(a_out_hold, out_stalled, out_valid_i, "result dropped while stalled")

  // the empty marker is the whole run
  `SPA_ASSERT_NOW(a_marker_last, marker, out_last_i, "empty marker without last")

  // the empty marker carries a zero term
  `SPA_ASSERT_NOW(a_marker_zero, marker, marker_zero, "empty marker not zero")

  // a compute request blocks further requests
  `SPA_ASSERT_NEXT(a_compute_busy, compute_taken, !in_ready_i, "request taken during compute")

endmodule

bind sparse_polynomial_adder_unit spa_checker u_spa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (term_i.valid),
  .in_ready_i    (term_i.ready),
  .in_opcode_i   (term_i.opcode),
  .out_valid_i   (sum_o.valid),
  .out_ready_i   (sum_o.ready),
  .out_degree_i  (sum_o.sum_degree),
  .out_coef_i    (sum_o.sum_coef),
  .out_present_i (sum_o.present),
  .out_last_i    (sum_o.last)
);

// File: verif/testbench.sv
// Self-checking testbench for sparse_polynomial_adder_unit: loads P and Q terms,
// requests sums, predicts every emitted term and compares each one field by field.
// Depends on spa_pkg, spa_term_if, spa_sum_if and sparse_polynomial_adder_unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import spa_pkg::*;

  localparam int unsigned MaxTerms    = 8;
  localparam int unsigned DegBits     = 8;
  localparam int unsigned IdxW        = $clog2(MaxTerms);
  localparam bit          SideP       = 1'b0;
  localparam bit          SideQ       = 1'b1;
  localparam int unsigned DrainCycles = 200;
  localparam int unsigned QuietLimit  = 4000;
  localparam logic [OpcodeW-1:0] OpUnused = 2'd3;
  localparam logic [DegW-1:0]    DegMask  = DegW'((1 << DegBits) - 1);

  typedef struct {
    logic [DegW-1:0]         degree;
    logic signed [CoefW-1:0] coef;
    logic                    present;
    logic                    overflow;
    logic                    last;
  } sum_term_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  spa_term_if term_if ();
  spa_sum_if  sum_if ();

  sparse_polynomial_adder_unit #(
    .MAX_TERMS  (MaxTerms),
    .DEGREE_BITS(DegBits)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .term_i(term_if),
    .sum_o (sum_if)
  );

  // Predicted term stores, indexed by side (P or Q)
  logic [DegW-1:0]         deg_store  [2][MaxTerms];
  logic signed [CoefW-1:0] coef_store [2][MaxTerms];
  int unsigned             term_count [2] = '{0, 0};
  logic                    store_dropped = 1'b0;
  sum_term_t               expected_sums[$];

  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned idle_pct       = 0;
  int unsigned stall_pct      = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Update the predicted stores for one accepted request; a compute queues its sums
  function automatic void apply_term_request(logic [OpcodeW-1:0] op, logic [DegW-1:0] deg,
                                             logic signed [CoefW-1:0] coef);
    bit          side;
    int unsigned i;
    int unsigned j;
    bit          hit;
    sum_term_t   run[$];
    case (op)
      OP_LOAD_P, OP_LOAD_Q: begin
        side = (op == OP_LOAD_P) ? SideP : SideQ;
        if (term_count[side] >= MaxTerms) begin
          store_dropped = 1'b1;
        end else begin
          deg_store[side][IdxW'(term_count[side])]  = deg & DegMask;
          coef_store[side][IdxW'(term_count[side])] = coef;
          term_count[side]++;
        end
      end
      OP_COMPUTE: begin
        if (term_count[SideP] == 0 && term_count[SideQ] == 0) begin
          run.push_back('{'0, '0, 1'b0, store_dropped, 1'b0});
        end else begin
          // P terms in load order, one sum per matching Q term
          for (i = 0; i < term_count[SideP]; i++) begin
            hit = 1'b0;
            for (j = 0; j < term_count[SideQ]; j++) begin
              if (deg_store[SideQ][IdxW'(j)] == deg_store[SideP][IdxW'(i)]) begin
                hit = 1'b1;
                run.push_back('{deg_store[SideQ][IdxW'(j)],
                                coef_store[SideP][IdxW'(i)] + coef_store[SideQ][IdxW'(j)],
                                1'b1, store_dropped, 1'b0});
              end
            end
            if (!hit) begin
              run.push_back('{deg_store[SideP][IdxW'(i)], coef_store[SideP][IdxW'(i)], 1'b1,
                              store_dropped, 1'b0});
            end
          end
          // then Q terms that no P term matched
          for (j = 0; j < term_count[SideQ]; j++) begin
            hit = 1'b0;
            for (i = 0; i < term_count[SideP]; i++) begin
              if (deg_store[SideQ][IdxW'(j)] == deg_store[SideP][IdxW'(i)]) hit = 1'b1;
            end
            if (!hit) begin
              run.push_back('{deg_store[SideQ][IdxW'(j)], coef_store[SideQ][IdxW'(j)], 1'b1,
                              store_dropped, 1'b0});
            end
          end
        end
        run[run.size()-1].last = 1'b1;
        foreach (run[k]) expected_sums.push_back(run[k]);
        term_count[SideP] = 0;
        term_count[SideQ] = 0;
        store_dropped     = 1'b0;
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string field, logic [CoefW-1:0] want,
                                      logic [CoefW-1:0] got);
    if (got !== want) begin
      $error("%s: expected 'h%0h, got 'h%0h", field, want, got);
      mismatch_count++;
    end
  endfunction

  // Predict on accepted requests, then check accepted sums against the oldest prediction
  always @(posedge clk_i) begin : check_sums
    sum_term_t want;
    if (rst_ni) begin
      if (term_if.valid && term_if.ready) begin
        apply_term_request(term_if.opcode, term_if.term_degree, term_if.term_coef);
      end
      if (sum_if.valid && sum_if.ready) begin
        if (expected_sums.size() == 0) begin
          $error("unexpected sum term: degree 'h%0h coef 'h%0h", sum_if.sum_degree,
                 sum_if.sum_coef);
          mismatch_count++;
        end else begin
          want = expected_sums.pop_front();
          check_field("sum_degree", CoefW'(want.degree), CoefW'(sum_if.sum_degree));
          check_field("sum_coef", want.coef, sum_if.sum_coef);
          check_field("present", CoefW'(want.present), CoefW'(sum_if.present));
          check_field("overflow", CoefW'(want.overflow), CoefW'(sum_if.overflow));
          check_field("last", CoefW'(want.last), CoefW'(sum_if.last));
        end
      end
    end
  end

  // Sum channel back-pressure
  always @(posedge clk_i) begin
    if (rst_ni) sum_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: too long without any request moving on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((term_if.valid && term_if.ready) || (sum_if.valid && sum_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QuietLimit) begin
        $display("testbench: errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Send one term request; returns at the edge where it is accepted
  task automatic send_term(logic [OpcodeW-1:0] op, logic [DegW-1:0] deg,
                           logic signed [CoefW-1:0] coef);
    while ($urandom_range(99) < idle_pct) begin
      term_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    term_if.valid       <= 1'b1;
    term_if.opcode      <= op;
    term_if.term_degree <= deg;
    term_if.term_coef   <= coef;
    do @(posedge clk_i); while (!term_if.ready);
  endtask

  // Stop sending until every predicted sum has come out
  task automatic hold_until_drained();
    term_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_sums.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [CoefW-1:0] pick_coef();
    case ($urandom_range(7))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return -32'sd1;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // Random P/Q pairs, each closed by a compute; degrees often clustered so they match
  task automatic random_polynomials(int unsigned item_goal);
    int unsigned     sent;
    int unsigned     n_p;
    int unsigned     n_q;
    int unsigned     base;
    bit              clustered;
    logic [DegW-1:0] deg;
    sent = 0;
    while (sent < item_goal) begin
      n_p       = $urandom_range(9);
      n_q       = $urandom_range(9);
      clustered = ($urandom_range(3) != 0);
      base      = $urandom_range(250);
      while (n_p + n_q > 0) begin
        if ($urandom_range(19) == 0) send_term(OpUnused, DegW'($urandom), $urandom);
        deg = clustered ? DegW'(base + $urandom_range(5)) : DegW'($urandom_range(255));
        if (n_q == 0 || (n_p != 0 && $urandom_range(1) == 0)) begin
          send_term(OP_LOAD_P, deg, pick_coef());
          n_p--;
        end else begin
          send_term(OP_LOAD_Q, deg, pick_coef());
          n_q--;
        end
        sent++;
      end
      send_term(OP_COMPUTE, DegW'($urandom), $urandom);
      sent++;
      if ($urandom_range(5) == 0) hold_until_drained();
    end
    hold_until_drained();
  endtask

  // Empty marker, wrapping sums at both ends, unmatched terms, ignored opcode
  task automatic test_corner_terms();
    send_term(OP_COMPUTE, 8'd0, 32'sd0);
    send_term(OP_LOAD_P, 8'd0, 32'sh7fffffff);
    send_term(OP_LOAD_Q, 8'd0, 32'sd1);
    send_term(OP_LOAD_P, 8'd255, 32'sh80000000);
    send_term(OP_LOAD_Q, 8'd255, -32'sd1);
    send_term(OpUnused, 8'd255, -32'sd1);
    send_term(OP_LOAD_P, 8'd7, 32'sd5);
    send_term(OP_LOAD_Q, 8'd9, -32'sd3);
    send_term(OP_COMPUTE, 8'd255, -32'sd1);
    hold_until_drained();
  endtask

  // Full stores with one dropped load: every pair matches, then the flag clears
  task automatic test_full_stores();
    for (int i = 0; i < MaxTerms + 1; i++) send_term(OP_LOAD_P, 8'hA5, i * 32'sh1000_0001);
    for (int i = 0; i < MaxTerms; i++) send_term(OP_LOAD_Q, 8'hA5, -i);
    send_term(OP_COMPUTE, 8'h5A, 32'sh5a5a5a5a);
    send_term(OP_COMPUTE, 8'd0, 32'sd0);
    hold_until_drained();
  endtask

  task automatic test_back_to_back();
    idle_pct  = 0;
    stall_pct = 0;
    random_polynomials(85);
  endtask

  task automatic test_sender_gaps();
    idle_pct  = 45;
    stall_pct = 0;
    random_polynomials(85);
  endtask

  task automatic test_receiver_stalls();
    idle_pct  = 0;
    stall_pct = 45;
    random_polynomials(85);
  endtask

  task automatic test_both_throttled();
    idle_pct  = 37;
    stall_pct = 37;
    random_polynomials(85);
  endtask

  initial begin
    rst_ni              = 1'b0;
    term_if.valid       = 1'b0;
    term_if.opcode      = OP_LOAD_P;
    term_if.term_degree = '0;
    term_if.term_coef   = '0;
    sum_if.ready        = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_corner_terms();
    test_full_stores();
    test_back_to_back();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_throttled();

    // let any stray result show up before closing
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_sums.size() != 0) begin
      $error("%0d predicted sum terms never arrived", expected_sums.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
